### design/urld_pkg.sv
// ----------------------------------------------------------------------------
// urld_pkg
// Shared types, constants and the percent-decoding step used by both stages.
// ----------------------------------------------------------------------------
package urld_pkg;

  localparam int unsigned MAX_BURST = 3;
  localparam logic [7:0]  PCT_CHAR  = 8'h25;

  typedef enum logic [2:0] {
    PH_NONE = 3'b001,
    PH_PCT  = 3'b010,
    PH_DIG  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  // up to three beats written into a queue in one cycle
  typedef struct packed {
    logic [1:0]                cnt;
    beat_t [MAX_BURST-1:0]     beat;
  } wr_grp_t;

  typedef struct packed {
    wr_grp_t    grp;
    phase_t     phase;
    logic [7:0] held;
  } stage_res_t;

  function automatic logic is_hex(logic [7:0] b);
    logic r;
    r = ((b >= 8'h30) && (b <= 8'h39)) || ((b >= 8'h41) && (b <= 8'h46)) ||
        ((b >= 8'h61) && (b <= 8'h66));
    return r;
  endfunction

  function automatic logic [3:0] hex_value(logic [7:0] b);
    logic [7:0] v;
    v = 8'h00;
    if ((b >= 8'h30) && (b <= 8'h39)) begin
      v = b - 8'h30;
    end else if ((b >= 8'h41) && (b <= 8'h46)) begin
      v = b - 8'h37;
    end else if ((b >= 8'h61) && (b <= 8'h66)) begin
      v = b - 8'h57;
    end
    return v[3:0];
  endfunction

  // one byte through one decoding stage
  function automatic stage_res_t stage_step(phase_t phase, logic [7:0] held,
                                            logic [7:0] b, logic last);
    stage_res_t r;
    logic [1:0] n;
    logic       taken;
    r       = '0;
    r.phase = PH_NONE;
    r.held  = held;
    n       = 2'd0;
    taken   = 1'b0;
    case (phase)
      PH_PCT: begin
        if (is_hex(b)) begin
          r.held  = b;
          r.phase = PH_DIG;
          taken   = 1'b1;
        end else begin
          r.grp.beat[n].data = PCT_CHAR;
          n = n + 2'd1;
        end
      end
      PH_DIG: begin
        if (is_hex(b)) begin
          r.grp.beat[n].data = {hex_value(held), hex_value(b)};
          n = n + 2'd1;
          taken = 1'b1;
        end else begin
          r.grp.beat[n].data = PCT_CHAR;
          n = n + 2'd1;
          r.grp.beat[n].data = held;
          n = n + 2'd1;
        end
      end
      default: begin
      end
    endcase
    if (!taken) begin
      if (b == PCT_CHAR) begin
        r.phase = PH_PCT;
      end else begin
        r.grp.beat[n].data = b;
        n = n + 2'd1;
      end
    end
    // end of string: flush whatever is held
    if (last) begin
      if (r.phase == PH_PCT) begin
        r.grp.beat[n].data = PCT_CHAR;
        n = n + 2'd1;
      end else if (r.phase == PH_DIG) begin
        r.grp.beat[n].data = PCT_CHAR;
        n = n + 2'd1;
        r.grp.beat[n].data = r.held;
        n = n + 2'd1;
      end
      r.phase = PH_NONE;
      r.held  = 8'h00;
      if (n != 2'd0) begin
        r.grp.beat[n - 2'd1].last = 1'b1;
      end
    end
    r.grp.cnt = n;
    return r;
  endfunction

endpackage

### design/urld_fifo.sv
// ----------------------------------------------------------------------------
// urld_fifo
// Beat queue taking up to three beats per cycle and giving one per cycle.
// ----------------------------------------------------------------------------
module urld_fifo #(
  parameter int unsigned DEPTH = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  urld_pkg::wr_grp_t wr,
  input  logic              rd_en,
  output urld_pkg::beat_t   rd_beat,
  output logic              empty,
  output logic              room
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned PW    = AW + 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned LIMIT = DEPTH - urld_pkg::MAX_BURST;

  urld_pkg::beat_t mem [DEPTH];

  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // pointer advance that wraps at any depth
  function automatic logic [AW-1:0] ptr_add(logic [AW-1:0] p, logic [AW-1:0] k);
    logic [PW-1:0] s;
    s = {1'b0, p} + {1'b0, k};
    if (s >= PW'(DEPTH)) begin
      s = s - PW'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign rd_beat = mem[rd_ptr_r];
  assign empty   = (cnt_r == '0);
  assign room    = (cnt_r <= CW'(LIMIT));

  always_comb begin
    wr_ptr_nxt = ptr_add(wr_ptr_r, AW'(wr.cnt));
    rd_ptr_nxt = ptr_add(rd_ptr_r, AW'(rd_en));
    cnt_nxt    = cnt_r + CW'(wr.cnt) - CW'(rd_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < int'(urld_pkg::MAX_BURST); i++) begin
      if (i < int'(wr.cnt)) begin
        mem[ptr_add(wr_ptr_r, AW'(i))] <= wr.beat[i];
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("queue fill above depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> !empty)
    else $error("read from empty queue");

  a_write_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.cnt != 2'd0) |-> room)
    else $error("burst written without room");

endmodule

### design/urld_front.sv
// ----------------------------------------------------------------------------
// urld_front
// First decoding stage: classifies each accepted byte and emits a burst.
// ----------------------------------------------------------------------------
module urld_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  output urld_pkg::wr_grp_t wr
);

  urld_pkg::phase_t     phase_r, phase_nxt;
  logic [7:0]           held_r, held_nxt;
  urld_pkg::stage_res_t res;

  always_comb begin
    res       = urld_pkg::stage_step(phase_r, held_r, in_byte, in_last);
    wr        = res.grp;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    if (accept) begin
      phase_nxt = res.phase;
      held_nxt  = res.held;
    end else begin
      wr.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= urld_pkg::PH_NONE;
      held_r  <= 8'h00;
    end else begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

### design/urld_back.sv
// ----------------------------------------------------------------------------
// urld_back
// Second decoding stage with bypass, and the second-pass enable register.
// ----------------------------------------------------------------------------
module urld_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr,
  input  logic              cfg_dual_pass,
  input  logic              mid_empty,
  input  urld_pkg::beat_t   mid_beat,
  input  logic              out_room,
  output logic              mid_pop,
  output urld_pkg::wr_grp_t wr
);

  logic                 dd_r, dd_nxt;
  urld_pkg::phase_t     phase_r, phase_nxt;
  logic [7:0]           held_r, held_nxt;
  urld_pkg::stage_res_t res;

  assign mid_pop = !mid_empty && out_room;

  always_comb begin
    res       = urld_pkg::stage_step(phase_r, held_r, mid_beat.data, mid_beat.last);
    dd_nxt    = dd_r;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    wr        = '0;
    if (mid_pop) begin
      if (dd_r) begin
        wr        = res.grp;
        phase_nxt = res.phase;
        held_nxt  = res.held;
      end else begin
        wr.cnt     = 2'd1;
        wr.beat[0] = mid_beat;
      end
    end
    // a mode write drops anything the second stage holds
    if (cfg_wr) begin
      dd_nxt    = cfg_dual_pass;
      phase_nxt = urld_pkg::PH_NONE;
      held_nxt  = 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dd_r    <= 1'b0;
      phase_r <= urld_pkg::PH_NONE;
      held_r  <= 8'h00;
    end else begin
      dd_r    <= dd_nxt;
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> (phase_r == urld_pkg::PH_NONE))
    else $error("second stage not cleared by mode write");

endmodule

### design/url_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming percent-decoder of byte strings with optional second pass.
// ----------------------------------------------------------------------------
// Input is a queue write side: a beat (in_byte, in_last) is taken when
// in_push is high and in_full low. Results come out of a queue read side:
// out_byte/out_last are valid while out_empty is low and leave on out_pop.
// The cfg channel (cfg_valid/cfg_ready, always ready) sets the second-pass
// enable; write it only while the block is drained. A write clears the
// second stage. Throughput is one input beat and one result beat per cycle
// while in_full and out_empty are low. Output of a taken byte enters the
// middle queue and the back stage moves it to the result queue once that
// has room. One input byte can emit up to three bytes per stage; these
// bursts land in both queues and drain one beat per cycle unless stalled.
// in_full rises when the middle queue has fewer than three free entries.
// If the receiver stops popping, the result queue fills, the back stage
// stops, the middle queue fills and in_full is raised; nothing is lost.
// Reset clears both queues, both stage states and the second-pass enable.
// ----------------------------------------------------------------------------
module url_percent_decoder #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic       out_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_dual_pass
);

  urld_pkg::wr_grp_t front_wr;
  urld_pkg::wr_grp_t back_wr;
  urld_pkg::beat_t   mid_beat;
  urld_pkg::beat_t   out_beat;
  logic              mid_empty;
  logic              mid_room;
  logic              mid_pop;
  logic              out_room;
  logic              accept;

  assign cfg_ready = 1'b1;
  assign in_full   = !mid_room;
  assign accept    = in_push && mid_room;
  assign out_byte  = out_beat.data;
  assign out_last  = out_beat.last;

  urld_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_byte),
    .in_last (in_last),
    .wr      (front_wr)
  );

  urld_fifo #(.DEPTH(QUEUE_DEPTH)) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (front_wr),
    .rd_en   (mid_pop),
    .rd_beat (mid_beat),
    .empty   (mid_empty),
    .room    (mid_room)
  );

  urld_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr        (cfg_valid),
    .cfg_dual_pass (cfg_dual_pass),
    .mid_empty     (mid_empty),
    .mid_beat      (mid_beat),
    .out_room      (out_room),
    .mid_pop       (mid_pop),
    .wr            (back_wr)
  );

  urld_fifo #(.DEPTH(QUEUE_DEPTH)) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (back_wr),
    .rd_en   (out_pop && !out_empty),
    .rd_beat (out_beat),
    .empty   (out_empty),
    .room    (out_room)
  );

endmodule

### tb/url_percent_decoder_tb.sv
// ----------------------------------------------------------------------------
// url_percent_decoder_tb
// Drives byte strings into the percent decoder, single and double pass, with
// random gaps on both queue sides, and checks every decoded beat against a
// cycle-free decoder kept inside the testbench.
// ----------------------------------------------------------------------------
module url_percent_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_PER_BYTE = 5;
  localparam int unsigned RAND_PER_PHASE = 64;

  typedef enum logic [1:0] {
    K_BEAT,
    K_CFG,
    K_DRAIN,
    K_RATES
  } step_kind_t;

  typedef struct {
    step_kind_t  kind;
    logic [7:0]  data;
    logic        last;
    int unsigned send_gap;
    int unsigned recv_gap;
  } step_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_dual_pass = 1'b0;

  step_t             pending[$];
  urld_pkg::beat_t   due_bytes[$];
  urld_pkg::beat_t   first_beats[$];
  urld_pkg::beat_t   second_beats[$];
  urld_pkg::phase_t  stage_ph [2] = '{urld_pkg::PH_NONE, urld_pkg::PH_NONE};
  logic [7:0]        stage_held [2] = '{8'h00, 8'h00};
  logic              double_on = 1'b0;
  logic              beat_taken = 1'b0;
  logic              cfg_taken = 1'b0;
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       quiet = 0;
  int unsigned       errors = 0;
  int unsigned       cycle_count = 0;

  url_percent_decoder i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_dual_pass (cfg_dual_pass)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- decoder

  function automatic bit is_hex_char(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
  endfunction

  function automatic logic [3:0] nibble(logic [7:0] b);
    logic [7:0] v;
    if (b >= "0" && b <= "9") begin
      v = b - "0";
    end else if (b >= "A" && b <= "F") begin
      v = b - "A" + 8'd10;
    end else if (b >= "a" && b <= "f") begin
      v = b - "a" + 8'd10;
    end else begin
      v = 8'h00;
    end
    return v[3:0];
  endfunction

  function automatic void emit(input int s, input logic [7:0] d);
    urld_pkg::beat_t bt;
    bt.data = d;
    bt.last = 1'b0;
    if (s == 0) begin
      first_beats.push_back(bt);
    end else begin
      second_beats.push_back(bt);
    end
  endfunction

  // one byte through pass s, output appended to that pass's queue
  function automatic void decode_step(input int s, input logic [7:0] b, input logic last);
    logic consumed;
    consumed = 1'b0;
    case (stage_ph[s])
      urld_pkg::PH_PCT: begin
        if (is_hex_char(b)) begin
          stage_held[s] = b;
          stage_ph[s] = urld_pkg::PH_DIG;
          consumed = 1'b1;
        end else begin
          emit(s, urld_pkg::PCT_CHAR);
          stage_ph[s] = urld_pkg::PH_NONE;
        end
      end
      urld_pkg::PH_DIG: begin
        if (is_hex_char(b)) begin
          emit(s, {nibble(stage_held[s]), nibble(b)});
          consumed = 1'b1;
        end else begin
          emit(s, urld_pkg::PCT_CHAR);
          emit(s, stage_held[s]);
        end
        stage_ph[s] = urld_pkg::PH_NONE;
      end
      default: begin
        stage_ph[s] = urld_pkg::PH_NONE;
      end
    endcase
    if (!consumed) begin
      if (b == urld_pkg::PCT_CHAR) begin
        stage_ph[s] = urld_pkg::PH_PCT;
      end else begin
        emit(s, b);
      end
    end
    if (last) begin
      if (stage_ph[s] == urld_pkg::PH_PCT) begin
        emit(s, urld_pkg::PCT_CHAR);
      end else if (stage_ph[s] == urld_pkg::PH_DIG) begin
        emit(s, urld_pkg::PCT_CHAR);
        emit(s, stage_held[s]);
      end
      stage_ph[s] = urld_pkg::PH_NONE;
      stage_held[s] = 8'h00;
      if (s == 0 && first_beats.size() != 0) begin
        first_beats[first_beats.size() - 1].last = 1'b1;
      end else if (s == 1 && second_beats.size() != 0) begin
        second_beats[second_beats.size() - 1].last = 1'b1;
      end
    end
  endfunction

  function automatic void decode_beat(input logic [7:0] b, input logic last);
    urld_pkg::beat_t produced[$];
    first_beats.delete();
    second_beats.delete();
    decode_step(0, b, last);
    if (double_on) begin
      foreach (first_beats[k]) begin
        decode_step(1, first_beats[k].data, first_beats[k].last);
      end
      produced = second_beats;
    end else begin
      produced = first_beats;
    end
    foreach (produced[k]) begin
      if (k < MAX_PER_BYTE) begin
        due_bytes.push_back(produced[k]);
      end
    end
  endfunction

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  // --------------------------------------------------------------- stimulus

  function automatic void push_beat(input logic [7:0] d, input logic last);
    step_t st;
    st = '{K_BEAT, d, last, 0, 0};
    pending.push_back(st);
  endfunction

  function automatic void push_text(input string txt, input bit end_last);
    for (int k = 0; k < txt.len(); k++) begin
      push_beat(txt[k], end_last && (k == txt.len() - 1));
    end
  endfunction

  function automatic void push_cfg(input logic v);
    step_t st;
    st = '{K_CFG, {7'd0, v}, 1'b0, 0, 0};
    pending.push_back(st);
  endfunction

  function automatic void push_rates(input int unsigned send_gap, input int unsigned recv_gap);
    step_t st;
    st = '{K_RATES, 8'h00, 1'b0, send_gap, recv_gap};
    pending.push_back(st);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + nib;
    end
    return ($urandom_range(1) ? 8'h41 : 8'h61) + nib - 8'd10;
  endfunction

  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    do begin
      b = 8'($urandom_range(255));
    end while (is_hex_char(b));
    return b;
  endfunction

  // escapes most often (some double encoded), plus raw bytes, broken escapes and lone hex digits
  function automatic int unsigned add_random_string(input int unsigned tokens);
    logic [7:0]  s[$];
    int unsigned r;
    for (int t = 0; t < tokens; t++) begin
      r = $urandom_range(99);
      if (r < 45) begin
        s.push_back(urld_pkg::PCT_CHAR);
        if ($urandom_range(3) == 0) begin
          s.push_back("2");
          s.push_back("5");
        end
        s.push_back(hex_char(4'($urandom_range(15))));
        s.push_back(hex_char(4'($urandom_range(15))));
      end else if (r < 75) begin
        s.push_back(8'($urandom_range(255)));
      end else if (r < 90) begin
        s.push_back(urld_pkg::PCT_CHAR);
        if ($urandom_range(1)) begin
          s.push_back(hex_char(4'($urandom_range(15))));
        end
        if ($urandom_range(3) != 0) begin
          s.push_back(non_hex_byte());
        end
      end else begin
        s.push_back(hex_char(4'($urandom_range(15))));
      end
    end
    foreach (s[k]) begin
      push_beat(s[k], k == s.size() - 1);
    end
    return s.size();
  endfunction

  // ----------------------------------------------------------------- driver

  always @(negedge clk) begin : drive
    logic  push_nxt;
    logic  cfg_nxt;
    step_t st;
    push_nxt = in_push && !beat_taken;
    cfg_nxt = cfg_valid && !cfg_taken;
    if (rst_n && !push_nxt && !cfg_nxt && pending.size() != 0) begin
      st = pending[0];
      case (st.kind)
        K_BEAT: begin
          if ($urandom_range(99) >= send_idle_pct) begin
            in_byte <= st.data;
            in_last <= st.last;
            push_nxt = 1'b1;
            void'(pending.pop_front());
          end
        end
        K_CFG, K_DRAIN: begin
          // hold off until the block has drained and settled
          if (due_bytes.size() != 0) begin
            quiet = 0;
          end else if (quiet < SETTLE_CYCLES) begin
            quiet++;
          end else begin
            quiet = 0;
            if (st.kind == K_CFG) begin
              cfg_dual_pass <= st.data[0];
              cfg_nxt = 1'b1;
            end
            void'(pending.pop_front());
          end
        end
        default: begin
          send_idle_pct = st.send_gap;
          recv_idle_pct = st.recv_gap;
          void'(pending.pop_front());
        end
      endcase
    end
    in_push <= push_nxt;
    cfg_valid <= cfg_nxt;
    out_pop <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : observe
    urld_pkg::beat_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (due_bytes.size() == 0) begin
          note_error($sformatf("unexpected beat: byte %02h last %0b", out_byte, out_last));
        end else begin
          want = due_bytes.pop_front();
          if (out_byte !== want.data || out_last !== want.last) begin
            note_error($sformatf("mismatch: byte exp %02h got %02h, last exp %0b got %0b",
                                 want.data, out_byte, want.last, out_last));
          end
        end
      end
      if (in_push && !in_full) begin
        decode_beat(in_byte, in_last);
      end
      if (cfg_valid && cfg_ready) begin
        // a mode write drops whatever the second pass holds
        double_on = cfg_dual_pass;
        stage_ph[1] = urld_pkg::PH_NONE;
        stage_held[1] = 8'h00;
      end
    end
    beat_taken <= rst_n && in_push && !in_full;
    cfg_taken <= rst_n && cfg_valid && cfg_ready;
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ------------------------------------------------------------------- test

  initial begin : run
    int unsigned sent;
    bit          paused;
    push_rates(33, 80);
    push_cfg(1'b0);
    push_text("%00", 1'b1);
    push_beat(8'hFF, 1'b0);
    push_text("%fF", 1'b1);
    push_text("%%4", 1'b1);          // lone percent, then a percent and digit at the end
    push_text("%4g", 1'b1);          // one digit only
    push_beat(8'h00, 1'b0);
    push_text("%", 1'b1);            // held percent flushed at end of string
    push_cfg(1'b1);
    push_text("%2541", 1'b1);
    push_text("%25", 1'b0);          // second pass holds a percent here
    push_cfg(1'b0);
    push_text("41", 1'b1);
    sent = 0;
    for (int p = 0; p < 3; p++) begin
      if (p == 1) begin
        push_rates(80, 33);
      end else if (p == 2) begin
        push_rates(0, 0);
      end
      push_cfg(p != 1);
      paused = 1'b0;
      while (sent < (p + 1) * RAND_PER_PHASE) begin
        sent += add_random_string($urandom_range(1, 6));
        if (!paused && sent >= p * RAND_PER_PHASE + RAND_PER_PHASE / 2) begin
          pending.push_back('{K_DRAIN, 8'h00, 1'b0, 0, 0});
          paused = 1'b1;
        end
        if ($urandom_range(9) == 0) begin
          push_cfg(1'($urandom_range(1)));
        end
      end
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    do begin
      @(posedge clk);
    end while (pending.size() != 0 || due_bytes.size() != 0 || in_push || cfg_valid);
    repeat (20) @(posedge clk);

    if (errors == 0 && due_bytes.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
